>>> rtl/earng_pkg.sv
`default_nettype none

package earng_pkg;

	// averaging window
	localparam int AVG_SHIFT = 4;
	localparam int ECHO_W    = 16;
	localparam int SUM_W     = ECHO_W + AVG_SHIFT;
	localparam int CNT_W     = AVG_SHIFT;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO  = 1'b1;
	localparam int CFG_DATA_W = 16;

	// unit modes, the unused code shows microseconds
	localparam logic [1:0] MODE_CM = 2'd0;
	localparam logic [1:0] MODE_IN = 2'd1;
	localparam logic [1:0] MODE_US = 2'd2;

	localparam logic [ECHO_W-1:0] MAX_ECHO_RESET = 16'd64000;

	// reciprocals for constant division, exact over 16-bit operands
	localparam logic [18:0] CM_RECIP     = 19'd289263;   // 2^24 / 58
	localparam logic [16:0] IN_RECIP     = 17'd113360;   // 2^24 / 148
	localparam logic [15:0] DIV10_RECIP  = 16'd52429;    // 2^19 / 10
	localparam logic [16:0] DIV100_RECIP = 17'd83887;    // 2^23 / 100
	localparam logic [16:0] DIV1K_RECIP  = 17'd67109;    // 2^26 / 1000
	localparam logic [16:0] DIV10K_RECIP = 17'd107375;   // 2^30 / 10000

	// segment patterns
	localparam logic [7:0] SEG_PREFIX_DIST = 8'hD0;
	localparam logic [7:0] SEG_PREFIX_TIME = 8'hF8;
	localparam logic [7:0] SEG_LET_CM      = 8'hD8;
	localparam logic [7:0] SEG_LET_IN      = 8'h86;
	localparam logic [7:0] SEG_LET_DIST    = 8'hD4;
	localparam logic [7:0] SEG_LET_US_HI   = 8'h9C;
	localparam logic [7:0] SEG_LET_US_LO   = 8'hED;
	localparam logic [7:0] SEG_BLANK       = 8'h00;
	localparam logic [7:0] SEG_ZERO        = 8'h3F;

	typedef struct packed {
		logic as_time;
		logic inch;
		logic ok;
	} disp_flags_t;

	// value and its quotients by 10, 100, 1000, 10000
	typedef struct packed {
		logic [15:0] q0;
		logic [12:0] q1;
		logic [9:0]  q2;
		logic [6:0]  q3;
		logic [2:0]  q4;
	} quot_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/earng_seg.sv
`default_nettype none

module earng_seg
	import earng_pkg::*;
(
	input  wire quot_t       quot,
	input  wire disp_flags_t flags,
	output logic [63:0]      segs
);

	logic [3:0] d0, d1, d2, d3, d4;

	// digit = q(k) - 10*q(k+1), only the low nibble matters
	always_comb begin
		d0 = 4'(quot.q0[3:0] - {quot.q1[0], 3'b000} - {quot.q1[2:0], 1'b0});
		d1 = 4'(quot.q1[3:0] - {quot.q2[0], 3'b000} - {quot.q2[2:0], 1'b0});
		d2 = 4'(quot.q2[3:0] - {quot.q3[0], 3'b000} - {quot.q3[2:0], 1'b0});
		d3 = 4'(quot.q3[3:0] - {quot.q4[0], 3'b000} - {quot.q4[2:0], 1'b0});
		d4 = {1'b0, quot.q4};
	end

	always_comb begin
		segs[23:16] = seg_of(d0);
		segs[31:24] = seg_of(d1);
		segs[39:32] = seg_of(d2);
		if (flags.as_time) begin
			segs[7:0]   = SEG_LET_US_LO;
			segs[15:8]  = SEG_LET_US_HI;
			segs[47:40] = seg_of(d3);
			segs[55:48] = seg_of(d4);
			segs[63:56] = SEG_PREFIX_TIME;
		end else begin
			segs[7:0]   = SEG_LET_DIST;
			segs[15:8]  = flags.inch ? SEG_LET_IN : SEG_LET_CM;
			segs[47:40] = SEG_BLANK;
			segs[55:48] = SEG_BLANK;
			segs[63:56] = SEG_PREFIX_DIST;
		end
	end

endmodule

`default_nettype wire

>>> rtl/echo_average_range_display.sv
// channel   dir  beat contents
// s_axis    in   tdata[15:0] echo_ticks
// m_axis    out  tdata seg_pos0..seg_pos7 (8 bits each, pos0 lowest), tuser[0] in_range
// cfg       in   cfg_wr_en, cfg_index (0 unit_mode, 1 max_echo_ticks), cfg_wdata
//
// one input beat accepted per cycle while s_axis_tready is high; every 16th beat closes a window and yields one result
// a result passes through four registers loaded in turn:
//   average (loaded at the edge that takes the beat closing its window), range check and
//   scale by unit (reciprocal multiply), split into decimal quotients (reciprocal multiplies),
//   then digit extraction and segment lookup
// each stage has its own valid and holds under stall; bubbles collapse
// async active-low reset clears the window sum, count, stage valids and config registers; data registers are not reset
`default_nettype none

module echo_average_range_display
	import earng_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	// input stream
	input  wire                  s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire  [15:0]          s_axis_tdata,   // [15:0] echo_ticks
	// output stream
	output logic                 m_axis_tvalid,
	input  wire                  m_axis_tready,
	output logic [63:0]          m_axis_tdata,   // seg_pos0 [7:0] .. seg_pos7 [63:56]
	output logic [0:0]           m_axis_tuser,   // [0] in_range
	// configuration writes
	input  wire                  cfg_wr_en,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [1:0]        unit_mode_q;
	logic [ECHO_W-1:0] max_echo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode_q <= MODE_CM;
			max_echo_q  <= MAX_ECHO_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_UNIT_MODE: unit_mode_q <= cfg_wdata[1:0];
				REG_MAX_ECHO:  max_echo_q  <= cfg_wdata[ECHO_W-1:0];
				default:       ;
			endcase
		end
	end

	// stage ready chain, a stage loads when empty or when its successor loads
	logic v_s1, v_s2, v_s3;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_out = !m_axis_tvalid || m_axis_tready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;

	assign s_axis_tready = rdy_s1;

	// window accumulator
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_beat;
	logic             win_last;
	logic [SUM_W-1:0] sum_next;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign win_last = (cnt_q == {CNT_W{1'b1}});
	assign sum_next = sum_q + SUM_W'(s_axis_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (in_beat) begin
			if (win_last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// stage 1: window average
	logic [ECHO_W-1:0] avg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_beat && win_last;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_beat && win_last) begin
			avg_s1 <= sum_next[SUM_W-1:AVG_SHIFT];
		end
	end

	// stage 2: range check and unit scaling
	logic [34:0]       cm_prod;
	logic [32:0]       in_prod;
	logic              ok_c;
	logic [15:0]       shown_c;
	disp_flags_t       flags_c;
	logic [15:0]       shown_s2;
	disp_flags_t       flags_s2;

	assign cm_prod = 35'(avg_s1) * 35'(CM_RECIP);
	assign in_prod = 33'(avg_s1) * 33'(IN_RECIP);
	assign ok_c    = (avg_s1 <= max_echo_q);

	always_comb begin
		flags_c.ok   = ok_c;
		flags_c.inch = (unit_mode_q == MODE_IN);
		priority if (!ok_c) begin
			// out of range: zero in microsecond format
			shown_c         = '0;
			flags_c.as_time = 1'b1;
		end else if (unit_mode_q == MODE_CM) begin
			shown_c         = 16'(cm_prod[34:24]);
			flags_c.as_time = 1'b0;
		end else if (unit_mode_q == MODE_IN) begin
			shown_c         = 16'(in_prod[32:24]);
			flags_c.as_time = 1'b0;
		end else begin
			// microseconds, also the unused mode code
			shown_c         = avg_s1;
			flags_c.as_time = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			shown_s2 <= shown_c;
			flags_s2 <= flags_c;
		end
	end

	// stage 3: decimal quotients by reciprocal multiply
	logic [31:0] p10;
	logic [32:0] p100, p1k, p10k;
	quot_t       quot_c;
	quot_t       quot_s3;
	disp_flags_t flags_s3;

	assign p10  = 32'(shown_s2) * 32'(DIV10_RECIP);
	assign p100 = 33'(shown_s2) * 33'(DIV100_RECIP);
	assign p1k  = 33'(shown_s2) * 33'(DIV1K_RECIP);
	assign p10k = 33'(shown_s2) * 33'(DIV10K_RECIP);

	always_comb begin
		quot_c.q0 = shown_s2;
		quot_c.q1 = p10[31:19];
		quot_c.q2 = p100[32:23];
		quot_c.q3 = p1k[32:26];
		quot_c.q4 = p10k[32:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			quot_s3  <= quot_c;
			flags_s3 <= flags_s2;
		end
	end

	// output register: digits and segment patterns
	logic [63:0] segs_c;

	earng_seg u_seg (
		.quot  (quot_s3),
		.flags (flags_s3),
		.segs  (segs_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (rdy_out) begin
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			m_axis_tdata <= segs_c;
			m_axis_tuser <= flags_s3.ok;
		end
	end

	// window wraps cleanly after its last beat
	a_win_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && win_last |=> (cnt_q == '0) && (sum_q == '0))
		else $error("window did not clear after its last beat");

	// input only stalls when the first stage is occupied
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1)
		else $error("input stalled with empty first stage");

	// an out-of-range result shows zero in time format
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			(m_axis_tdata[63:56] == SEG_PREFIX_TIME) && (m_axis_tdata[23:16] == SEG_ZERO)
			&& (m_axis_tdata[55:48] == SEG_ZERO))
		else $error("out-of-range result not shown as zero time");

	// distance results blank the two top digits
	a_dist_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[63:56] == SEG_PREFIX_DIST) |->
			(m_axis_tdata[47:40] == SEG_BLANK) && (m_axis_tdata[55:48] == SEG_BLANK)
			&& m_axis_tuser[0])
		else $error("distance result with lit upper digits");

endmodule

`default_nettype wire
